>>> design/sccbm_pkg.sv
// shared types, constants and bus segment table for the sccb register master
// no dependencies
`default_nettype none

package sccbm_pkg;

   localparam int MAX_READ_BYTES_DEFAULT = 16;
   localparam logic [7:0] SELECT_ADDRESS_RESET = 8'hDC;
   localparam logic [9:0] TICKS_PER_UNIT_RESET = 10'd48;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic {
      CSR_SELECT_ADDRESS = 1'b0,
      CSR_TICKS_PER_UNIT = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_ST3,
      PH_TX0, PH_TX1, PH_TX2, PH_TX3, PH_PRE,
      PH_AK0, PH_AK1, PH_RX0, PH_RX1,
      PH_MA0, PH_MA1, PH_MA2, PH_NA0, PH_NA1, PH_NA2,
      PH_SP0, PH_SP1, PH_SP2, PH_SP3
   } phase_type;

   typedef enum logic [1:0] {
      SDA_LOW  = 2'd0,
      SDA_HIGH = 2'd1,
      SDA_BIT  = 2'd2
   } sda_code_type;

   typedef struct packed {
      logic         scl;
      sda_code_type sda;
      logic         drive;
      logic [1:0]   units_m1;
   } seg_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic [7:0] read_data;
      logic       read_valid;
      logic       last_byte;
      logic       done_res;
      logic       status;
   } rsp_type;

   function automatic seg_type seg_info(input phase_type ph);
      seg_type s;
      case (ph)
         PH_IDLE: s = '{1'b0, SDA_HIGH, 1'b1, 2'd0};
         PH_ST0:  s = '{1'b0, SDA_HIGH, 1'b1, 2'd0};
         PH_ST1:  s = '{1'b1, SDA_HIGH, 1'b1, 2'd0};
         PH_ST2:  s = '{1'b1, SDA_LOW,  1'b1, 2'd0};
         PH_ST3:  s = '{1'b0, SDA_LOW,  1'b1, 2'd1};
         PH_TX0:  s = '{1'b0, SDA_BIT,  1'b1, 2'd0};
         PH_TX1:  s = '{1'b1, SDA_BIT,  1'b1, 2'd1};
         PH_TX2:  s = '{1'b0, SDA_BIT,  1'b1, 2'd0};
         PH_TX3:  s = '{1'b0, SDA_LOW,  1'b1, 2'd0};
         PH_PRE:  s = '{1'b0, SDA_LOW,  1'b1, 2'd0};
         PH_AK0:  s = '{1'b0, SDA_HIGH, 1'b0, 2'd0};
         PH_AK1:  s = '{1'b1, SDA_HIGH, 1'b0, 2'd0};
         PH_RX0:  s = '{1'b0, SDA_HIGH, 1'b0, 2'd2};
         PH_RX1:  s = '{1'b1, SDA_HIGH, 1'b0, 2'd1};
         PH_MA0:  s = '{1'b0, SDA_LOW,  1'b1, 2'd0};
         PH_MA1:  s = '{1'b1, SDA_LOW,  1'b1, 2'd1};
         PH_MA2:  s = '{1'b0, SDA_LOW,  1'b1, 2'd1};
         PH_NA0:  s = '{1'b0, SDA_HIGH, 1'b1, 2'd0};
         PH_NA1:  s = '{1'b1, SDA_HIGH, 1'b1, 2'd2};
         PH_NA2:  s = '{1'b0, SDA_HIGH, 1'b1, 2'd0};
         PH_SP0:  s = '{1'b0, SDA_LOW,  1'b1, 2'd0};
         PH_SP1:  s = '{1'b1, SDA_LOW,  1'b1, 2'd0};
         PH_SP2:  s = '{1'b1, SDA_HIGH, 1'b1, 2'd0};
         PH_SP3:  s = '{1'b0, SDA_HIGH, 1'b1, 2'd1};
         default: s = '{1'b0, SDA_HIGH, 1'b1, 2'd0};
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

>>> design/sccbm_fsm.sv
// bus sequencer: phase state, timing counters and byte shifter, advanced per request
// depends on sccbm_pkg
`default_nettype none

module sccbm_fsm
   import sccbm_pkg::*;
#(
   parameter int MAX_READ_BYTES = MAX_READ_BYTES_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic [1:0] operation,
   input  wire logic [7:0] device_address,
   input  wire logic [7:0] reg_address,
   input  wire logic [7:0] write_value,
   input  wire logic [4:0] read_count,
   input  wire logic       sda_in,
   input  wire logic [7:0] select_address,
   input  wire logic [9:0] ticks_per_unit,
   output rsp_type         result
);

   localparam int BL_W = $clog2(MAX_READ_BYTES + 1);
   localparam int CW   = (BL_W > 5) ? BL_W : 5;

   localparam logic [1:0] BS_FIRST  = 2'd0;
   localparam logic [1:0] BS_SECOND = 2'd1;
   localparam logic [1:0] BS_THIRD  = 2'd2;
   localparam logic [1:0] BS_DATA   = 2'd3;

   phase_type       phase_ff, phase_in;
   logic [9:0]      unit_ff, unit_in;
   logic [1:0]      units_left_ff, units_left_in;
   logic [3:0]      bit_ff, bit_in;
   logic [7:0]      shift_ff, shift_in;
   logic [1:0]      stage_ff, stage_in;
   logic [BL_W-1:0] bytes_left_ff, bytes_left_in;
   logic            is_read_ff, is_read_in;
   logic [23:0]     held_ff, held_in;
   logic            scl_level_ff, scl_level_in;
   logic            sda_level_ff, sda_level_in;

   logic            start;
   logic [CW-1:0]   cnt;
   phase_type       ph;
   seg_type         seg;
   seg_type         seg_next;
   logic            sda_now;
   logic [9:0]      tpu;
   logic [10:0]     unit_p1;
   logic            seg_end;
   logic            do_enter;
   logic [3:0]      bit_p1;
   logic [7:0]      rx_byte;

   always_comb begin
      start = (phase_ff == PH_IDLE) &&
              ((operation == OP_WRITE) || (operation == OP_READ));
      cnt = CW'(read_count);
      if (cnt == '0) begin
         cnt = CW'(1);
      end
      if (cnt > CW'(MAX_READ_BYTES)) begin
         cnt = CW'(MAX_READ_BYTES);
      end

      ph            = start ? PH_ST0 : phase_ff;
      unit_in       = start ? '0 : unit_ff;
      units_left_in = start ? 2'd0 : units_left_ff;
      bit_in        = start ? 4'd0 : bit_ff;
      stage_in      = start ? BS_FIRST : stage_ff;
      is_read_in    = start ? (operation == OP_READ) : is_read_ff;
      held_in       = start ? {device_address, reg_address, write_value} : held_ff;
      bytes_left_in = start ? BL_W'(cnt) : bytes_left_ff;
      shift_in      = shift_ff;
      phase_in      = ph;
      scl_level_in  = scl_level_ff;
      sda_level_in  = sda_level_ff;

      seg      = seg_info(ph);
      seg_next = seg;
      sda_now  = (seg.sda == SDA_BIT) ? shift_ff[7] : seg.sda[0];
      tpu      = (ticks_per_unit == '0) ? 10'd1 : ticks_per_unit;
      unit_p1  = {1'b0, unit_in} + 11'd1;
      seg_end  = 1'b0;
      do_enter = 1'b0;
      bit_p1   = bit_in + 4'd1;
      rx_byte  = {shift_ff[6:0], sda_in};
      result   = '0;

      if (phase_ff == PH_IDLE && !start) begin
         result.scl       = scl_level_ff;
         result.sda_out   = sda_level_ff;
         result.sda_drive = 1'b1;
      end else begin
         result.scl       = seg.scl;
         result.sda_out   = sda_now;
         result.sda_drive = seg.drive;
         result.busy_res  = 1'b1;
         scl_level_in     = seg.scl;
         sda_level_in     = sda_now;

         if (unit_p1 >= {1'b0, tpu}) begin
            unit_in = '0;
            if (units_left_in == 2'd0) begin
               seg_end = 1'b1;
            end else begin
               units_left_in = units_left_in - 2'd1;
            end
         end else begin
            unit_in = unit_p1[9:0];
         end

         if (seg_end) begin
            case (ph)
               PH_ST3: begin
                  bit_in   = 4'd0;
                  phase_in = PH_TX0;
                  do_enter = 1'b1;
                  if (is_read_in && stage_in != BS_THIRD) begin
                     shift_in = select_address;
                  end else begin
                     shift_in = held_in[23:16];
                  end
               end
               PH_TX3: begin
                  shift_in = {shift_ff[6:0], 1'b0};
                  bit_in   = bit_p1;
                  do_enter = 1'b1;
                  if (bit_p1 >= 4'd8) begin
                     phase_in = is_read_in ? PH_PRE : PH_AK0;
                  end else begin
                     phase_in = PH_TX0;
                  end
               end
               PH_AK1: begin
                  if (sda_in) begin
                     result.done_res = 1'b1;
                     result.status   = 1'b1;
                     phase_in        = PH_IDLE;
                     scl_level_in    = 1'b0;
                     sda_level_in    = 1'b1;
                  end else begin
                     do_enter = 1'b1;
                     if (stage_in == BS_FIRST) begin
                        stage_in = BS_SECOND;
                        shift_in = held_in[15:8];
                        bit_in   = 4'd0;
                        phase_in = PH_TX0;
                     end else if (stage_in == BS_SECOND) begin
                        stage_in = BS_THIRD;
                        if (is_read_in) begin
                           phase_in = PH_ST0;
                        end else begin
                           shift_in = held_in[7:0];
                           bit_in   = 4'd0;
                           phase_in = PH_TX0;
                        end
                     end else if (!is_read_in) begin
                        phase_in = PH_SP0;
                     end else begin
                        stage_in = BS_DATA;
                        bit_in   = 4'd0;
                        shift_in = 8'd0;
                        phase_in = PH_RX0;
                     end
                  end
               end
               PH_RX1: begin
                  shift_in = rx_byte;
                  bit_in   = bit_p1;
                  do_enter = 1'b1;
                  if (bit_p1 >= 4'd8) begin
                     result.read_valid = 1'b1;
                     result.read_data  = rx_byte;
                     if (bytes_left_in <= BL_W'(1)) begin
                        result.last_byte = 1'b1;
                        bytes_left_in    = '0;
                        phase_in         = PH_NA0;
                     end else begin
                        bytes_left_in = bytes_left_in - BL_W'(1);
                        phase_in      = PH_MA0;
                     end
                  end else begin
                     phase_in = PH_RX0;
                  end
               end
               PH_MA2: begin
                  bit_in   = 4'd0;
                  shift_in = 8'd0;
                  phase_in = PH_RX0;
                  do_enter = 1'b1;
               end
               PH_NA2: begin
                  phase_in = PH_SP0;
                  do_enter = 1'b1;
               end
               PH_SP3: begin
                  result.done_res = 1'b1;
                  phase_in        = PH_IDLE;
                  scl_level_in    = 1'b0;
                  sda_level_in    = 1'b1;
               end
               default: begin
                  phase_in = phase_type'(ph + 5'd1);
                  do_enter = 1'b1;
               end
            endcase
         end

         if (do_enter) begin
            seg_next      = seg_info(phase_in);
            unit_in       = '0;
            units_left_in = seg_next.units_m1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         unit_ff       <= '0;
         units_left_ff <= '0;
         bit_ff        <= '0;
         shift_ff      <= '0;
         stage_ff      <= BS_FIRST;
         bytes_left_ff <= '0;
         is_read_ff    <= 1'b0;
         held_ff       <= '0;
         scl_level_ff  <= 1'b0;
         sda_level_ff  <= 1'b1;
      end else if (advance) begin
         phase_ff      <= phase_in;
         unit_ff       <= unit_in;
         units_left_ff <= units_left_in;
         bit_ff        <= bit_in;
         shift_ff      <= shift_in;
         stage_ff      <= stage_in;
         bytes_left_ff <= bytes_left_in;
         is_read_ff    <= is_read_in;
         held_ff       <= held_in;
         scl_level_ff  <= scl_level_in;
         sda_level_ff  <= sda_level_in;
      end
   end

endmodule

`default_nettype wire

>>> design/sccbm_rsp_reg.sv
// result register between the sequencer and the response channel
// depends on sccbm_pkg
`default_nettype none

module sccbm_rsp_reg
   import sccbm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type data_in,
   input  wire logic    out_ready,
   output logic         in_ready,
   output logic         out_valid,
   output rsp_type      data_out
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign data_out  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

>>> design/sccb_register_master_unit.sv
// sccb register master top level: configuration registers, sequencer, result register
// depends on sccbm_pkg, sccbm_fsm, sccbm_rsp_reg
`default_nettype none

// Each request is one bus tick or a command (write or read of a camera register) and
// yields exactly one response with the bus levels and status for that tick. A request
// is taken every cycle while the response register is empty or being drained, and its
// response appears in the following cycle; the sequencer does all of a tick's work in the
// cycle of acceptance. Bus phase lengths are whole delay units of ticks_per_unit ticks.

module sccb_register_master_unit
   import sccbm_pkg::*;
#(
   parameter int MAX_READ_BYTES = MAX_READ_BYTES_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_device_address,
   input  wire logic [7:0] req_reg_address,
   input  wire logic [7:0] req_write_value,
   input  wire logic [4:0] req_read_count,
   input  wire logic       req_sda_in,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_scl,
   output logic            rsp_sda_out,
   output logic            rsp_sda_drive,
   output logic            rsp_busy_res,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_read_valid,
   output logic            rsp_last_byte,
   output logic            rsp_done_res,
   output logic            rsp_status,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_index,
   input  wire logic [9:0] csr_write_data
);

   logic [7:0] select_address_ff;
   logic [9:0] ticks_per_unit_ff;
   logic       accept;
   rsp_type    step_result;
   rsp_type    rsp_data;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         select_address_ff <= SELECT_ADDRESS_RESET;
         ticks_per_unit_ff <= TICKS_PER_UNIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SELECT_ADDRESS: select_address_ff <= csr_write_data[7:0];
            CSR_TICKS_PER_UNIT: ticks_per_unit_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   sccbm_fsm #(
      .MAX_READ_BYTES(MAX_READ_BYTES)
   ) u_fsm (
      .clock          (clock),
      .reset          (reset),
      .advance        (accept),
      .operation      (req_operation),
      .device_address (req_device_address),
      .reg_address    (req_reg_address),
      .write_value    (req_write_value),
      .read_count     (req_read_count),
      .sda_in         (req_sda_in),
      .select_address (select_address_ff),
      .ticks_per_unit (ticks_per_unit_ff),
      .result         (step_result)
   );

   sccbm_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .data_in   (step_result),
      .out_ready (rsp_ready),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .data_out  (rsp_data)
   );

   assign rsp_scl        = rsp_data.scl;
   assign rsp_sda_out    = rsp_data.sda_out;
   assign rsp_sda_drive  = rsp_data.sda_drive;
   assign rsp_busy_res   = rsp_data.busy_res;
   assign rsp_read_data  = rsp_data.read_data;
   assign rsp_read_valid = rsp_data.read_valid;
   assign rsp_last_byte  = rsp_data.last_byte;
   assign rsp_done_res   = rsp_data.done_res;
   assign rsp_status     = rsp_data.status;

endmodule

`default_nettype wire

>>> verif/sccbm_tick_checker.sv
// response checker for the sccb register master: follows the bus sequencer one tick per
// accepted request and compares each accepted response with the oldest prediction
// depends on sccbm_pkg
`timescale 1ns / 100ps

module sccbm_tick_checker
   import sccbm_pkg::*;
#(
   parameter int READ_LIMIT = MAX_READ_BYTES_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_device_address,
   input  wire logic [7:0] req_reg_address,
   input  wire logic [7:0] req_write_value,
   input  wire logic [4:0] req_read_count,
   input  wire logic       req_sda_in,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic       rsp_scl,
   input  wire logic       rsp_sda_out,
   input  wire logic       rsp_sda_drive,
   input  wire logic       rsp_busy_res,
   input  wire logic [7:0] rsp_read_data,
   input  wire logic       rsp_read_valid,
   input  wire logic       rsp_last_byte,
   input  wire logic       rsp_done_res,
   input  wire logic       rsp_status,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_index,
   input  wire logic [9:0] csr_write_data,
   output int              failures
);

   typedef struct packed {
      logic         scl;
      sda_code_type sda;
      logic         drive;
      logic [1:0]   units_m1;
   } bus_step_type;

   phase_type  phase;
   logic [9:0] unit_count;
   logic [1:0] units_left;
   logic [3:0] bit_count;
   logic [7:0] shift_reg;
   logic [2:0] byte_stage;
   logic [4:0] bytes_left;
   logic       reading;
   logic [7:0] dev_held;
   logic [7:0] reg_held;
   logic [7:0] value_held;
   logic       scl_level;
   logic       sda_level;
   logic [7:0] select_address;
   logic [9:0] ticks_per_unit;
   rsp_type    pending_levels [$];
   rsp_type    predicted;
   rsp_type    oldest;

   initial failures = 0;

   function automatic bus_step_type step_of(input phase_type ph);
      bus_step_type s;
      case (ph)
         PH_ST0:  s = '{1'b0, SDA_HIGH, 1'b1, 2'd0};
         PH_ST1:  s = '{1'b1, SDA_HIGH, 1'b1, 2'd0};
         PH_ST2:  s = '{1'b1, SDA_LOW,  1'b1, 2'd0};
         PH_ST3:  s = '{1'b0, SDA_LOW,  1'b1, 2'd1};
         PH_TX0:  s = '{1'b0, SDA_BIT,  1'b1, 2'd0};
         PH_TX1:  s = '{1'b1, SDA_BIT,  1'b1, 2'd1};
         PH_TX2:  s = '{1'b0, SDA_BIT,  1'b1, 2'd0};
         PH_TX3:  s = '{1'b0, SDA_LOW,  1'b1, 2'd0};
         PH_PRE:  s = '{1'b0, SDA_LOW,  1'b1, 2'd0};
         PH_AK0:  s = '{1'b0, SDA_HIGH, 1'b0, 2'd0};
         PH_AK1:  s = '{1'b1, SDA_HIGH, 1'b0, 2'd0};
         PH_RX0:  s = '{1'b0, SDA_HIGH, 1'b0, 2'd2};
         PH_RX1:  s = '{1'b1, SDA_HIGH, 1'b0, 2'd1};
         PH_MA0:  s = '{1'b0, SDA_LOW,  1'b1, 2'd0};
         PH_MA1:  s = '{1'b1, SDA_LOW,  1'b1, 2'd1};
         PH_MA2:  s = '{1'b0, SDA_LOW,  1'b1, 2'd1};
         PH_NA0:  s = '{1'b0, SDA_HIGH, 1'b1, 2'd0};
         PH_NA1:  s = '{1'b1, SDA_HIGH, 1'b1, 2'd2};
         PH_NA2:  s = '{1'b0, SDA_HIGH, 1'b1, 2'd0};
         PH_SP0:  s = '{1'b0, SDA_LOW,  1'b1, 2'd0};
         PH_SP1:  s = '{1'b1, SDA_LOW,  1'b1, 2'd0};
         PH_SP2:  s = '{1'b1, SDA_HIGH, 1'b1, 2'd0};
         PH_SP3:  s = '{1'b0, SDA_HIGH, 1'b1, 2'd1};
         default: s = '{1'b0, SDA_HIGH, 1'b1, 2'd0};
      endcase
      return s;
   endfunction

   task automatic start_segment(input phase_type ph);
      bus_step_type s;
      s = step_of(ph);
      phase = ph;
      unit_count = '0;
      units_left = s.units_m1;
   endtask

   task automatic load_byte(input logic [7:0] value);
      shift_reg = value;
      bit_count = '0;
      start_segment(PH_TX0);
   endtask

   // one bus tick for the request being accepted now
   task automatic advance_bus_tick(output rsp_type r);
      bus_step_type s;
      logic [9:0]   span;
      logic         seg_done;
      logic         sda;
      r = '0;
      seg_done = 1'b0;
      if (phase == PH_IDLE && req_operation != OP_WRITE && req_operation != OP_READ) begin
         r.scl = scl_level;
         r.sda_out = sda_level;
         r.sda_drive = 1'b1;
      end else begin
         if (phase == PH_IDLE) begin
            reading = (req_operation == OP_READ);
            dev_held = req_device_address;
            reg_held = req_reg_address;
            value_held = req_write_value;
            bytes_left = (req_read_count == 5'd0) ? 5'd1 :
                         (req_read_count > READ_LIMIT) ? 5'(READ_LIMIT) : req_read_count;
            byte_stage = '0;
            bit_count = '0;
            start_segment(PH_ST0);
         end
         s = step_of(phase);
         sda = (s.sda == SDA_BIT) ? shift_reg[7] : (s.sda == SDA_HIGH);
         if (!s.drive) sda = 1'b1;
         r.scl = s.scl;
         r.sda_out = sda;
         r.sda_drive = s.drive;
         r.busy_res = 1'b1;
         scl_level = s.scl;
         sda_level = sda;

         span = (ticks_per_unit == 10'd0) ? 10'd1 : ticks_per_unit;
         if (unit_count + 11'd1 >= span) begin
            unit_count = '0;
            if (units_left == 2'd0) seg_done = 1'b1;
            else units_left = units_left - 2'd1;
         end else begin
            unit_count = unit_count + 10'd1;
         end

         if (seg_done) begin
            case (phase)
               PH_ST3: begin
                  if (reading && byte_stage != 3'd2) load_byte(select_address);
                  else load_byte(dev_held);
               end
               PH_TX3: begin
                  shift_reg = {shift_reg[6:0], 1'b0};
                  bit_count = bit_count + 4'd1;
                  if (bit_count >= 4'd8) start_segment(reading ? PH_PRE : PH_AK0);
                  else start_segment(PH_TX0);
               end
               PH_AK1: begin
                  if (req_sda_in) begin
                     r.done_res = 1'b1;
                     r.status = 1'b1;
                     phase = PH_IDLE;
                     scl_level = 1'b0;
                     sda_level = 1'b1;
                  end else if (byte_stage == 3'd0) begin
                     byte_stage = 3'd1;
                     load_byte(reg_held);
                  end else if (byte_stage == 3'd1) begin
                     byte_stage = 3'd2;
                     if (reading) start_segment(PH_ST0);
                     else load_byte(value_held);
                  end else if (!reading) begin
                     start_segment(PH_SP0);
                  end else begin
                     byte_stage = 3'd3;
                     bit_count = '0;
                     shift_reg = '0;
                     start_segment(PH_RX0);
                  end
               end
               PH_RX1: begin
                  shift_reg = {shift_reg[6:0], req_sda_in};
                  bit_count = bit_count + 4'd1;
                  if (bit_count >= 4'd8) begin
                     r.read_valid = 1'b1;
                     r.read_data = shift_reg;
                     if (bytes_left <= 5'd1) begin
                        r.last_byte = 1'b1;
                        bytes_left = '0;
                        start_segment(PH_NA0);
                     end else begin
                        bytes_left = bytes_left - 5'd1;
                        start_segment(PH_MA0);
                     end
                  end else begin
                     start_segment(PH_RX0);
                  end
               end
               PH_MA2: begin
                  bit_count = '0;
                  shift_reg = '0;
                  start_segment(PH_RX0);
               end
               PH_NA2: start_segment(PH_SP0);
               PH_SP3: begin
                  r.done_res = 1'b1;
                  phase = PH_IDLE;
                  scl_level = 1'b0;
                  sda_level = 1'b1;
               end
               default: start_segment(phase_type'(phase + 5'd1));
            endcase
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         if (failures < 100)
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase = PH_IDLE;
         unit_count = '0;
         units_left = '0;
         bit_count = '0;
         shift_reg = '0;
         byte_stage = '0;
         bytes_left = '0;
         reading = 1'b0;
         dev_held = '0;
         reg_held = '0;
         value_held = '0;
         scl_level = 1'b0;
         sda_level = 1'b1;
         select_address = SELECT_ADDRESS_RESET;
         ticks_per_unit = TICKS_PER_UNIT_RESET;
         pending_levels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_levels.size() == 0) begin
               if (failures < 100)
                  $display("%0t: response with no request waiting", $time);
               failures++;
            end else begin
               oldest = pending_levels.pop_front();
               compare_field("scl", 8'(oldest.scl), 8'(rsp_scl));
               compare_field("sda_out", 8'(oldest.sda_out), 8'(rsp_sda_out));
               compare_field("sda_drive", 8'(oldest.sda_drive), 8'(rsp_sda_drive));
               compare_field("busy_res", 8'(oldest.busy_res), 8'(rsp_busy_res));
               compare_field("read_data", oldest.read_data, rsp_read_data);
               compare_field("read_valid", 8'(oldest.read_valid), 8'(rsp_read_valid));
               compare_field("last_byte", 8'(oldest.last_byte), 8'(rsp_last_byte));
               compare_field("done_res", 8'(oldest.done_res), 8'(rsp_done_res));
               compare_field("status", 8'(oldest.status), 8'(rsp_status));
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_SELECT_ADDRESS) select_address = csr_write_data[7:0];
            else ticks_per_unit = csr_write_data;
         end
         if (req_valid && req_ready) begin
            advance_bus_tick(predicted);
            pending_levels.push_back(predicted);
         end
      end
   end

endmodule

>>> verif/sccb_register_master_unit_test.sv
// testbench top for the sccb register master: clock, reset, register writes and request
// stimulus acting as the camera slave; sccbm_tick_checker predicts and compares
// depends on sccbm_pkg, sccbm_tick_checker and the sccb_register_master_unit design
`timescale 1ns / 100ps

module sccb_register_master_unit_test;
   import sccbm_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   wire        req_ready;
   logic [1:0] req_operation = OP_TICK;
   logic [7:0] req_device_address = '0;
   logic [7:0] req_reg_address = '0;
   logic [7:0] req_write_value = '0;
   logic [4:0] req_read_count = '0;
   logic       req_sda_in = 1'b1;
   wire        rsp_valid;
   logic       rsp_ready = 1'b0;
   wire        rsp_scl;
   wire        rsp_sda_out;
   wire        rsp_sda_drive;
   wire        rsp_busy_res;
   wire  [7:0] rsp_read_data;
   wire        rsp_read_valid;
   wire        rsp_last_byte;
   wire        rsp_done_res;
   wire        rsp_status;
   logic       csr_write_enable = 1'b0;
   logic       csr_index = CSR_SELECT_ADDRESS;
   logic [9:0] csr_write_data = '0;
   int         failures;
   int         outstanding = 0;
   int         unit_ticks = int'(TICKS_PER_UNIT_RESET);
   int         stall_left = 0;
   bit         calm = 1'b0;

   sccb_register_master_unit dut (.*);

   sccbm_tick_checker checker_inst (.*);

   always #6 clock = ~clock;

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #100_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset)
         outstanding <= outstanding + int'(req_valid && req_ready)
                        - int'(rsp_valid && rsp_ready);
   end

   task automatic send_request(input logic [1:0] op, input logic [7:0] dev, regn, value,
                               input logic [4:0] count, input logic sda);
      req_valid <= 1'b1;
      req_operation <= op;
      req_device_address <= dev;
      req_reg_address <= regn;
      req_write_value <= value;
      req_read_count <= count;
      req_sda_in <= sda;
      do @(posedge clock); while (!req_ready);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic send_tick(input logic [1:0] op, input logic sda);
      send_request(op, 8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom), sda);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic configure(input logic [7:0] select_byte, input logic [9:0] unit_len);
      drain_responses();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_SELECT_ADDRESS;
      csr_write_data <= {2'b00, select_byte};
      @(posedge clock);
      csr_index <= CSR_TICKS_PER_UNIT;
      csr_write_data <= unit_len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      unit_ticks = int'(unit_len);
   endtask

   // one command and the ticks of its transaction; acks[j] is the slave's level at
   // the acknowledge sample of byte j, data bits and everything else are random
   task automatic run_transfer(input logic is_read, input logic [7:0] dev, regn, value,
                               input logic [4:0] count, input logic [2:0] acks);
      int         span;
      int         bytes;
      int         length;
      int         ack_at [3];
      logic [1:0] op;
      logic       sda;
      span = (unit_ticks == 0) ? 1 : unit_ticks;
      bytes = (count == 5'd0) ? 1 : (count > MAX_READ_BYTES_DEFAULT) ?
              MAX_READ_BYTES_DEFAULT : int'(count);
      for (int j = 0; j < 3; j++)
         ack_at[j] = is_read ? (48 + 43 * j + ((j == 2) ? 5 : 0)) * span - 1
                             : (47 + 42 * j) * span - 1;
      length = is_read ? (144 + 45 * bytes) * span : 136 * span;
      for (int j = 2; j >= 0; j--)
         if (acks[j]) length = ack_at[j] + 1;
      send_request(is_read ? OP_READ : OP_WRITE, dev, regn, value, count, 1'($urandom));
      for (int t = 1; t < length; t++) begin
         op = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : OP_TICK;
         sda = 1'($urandom);
         for (int j = 0; j < 3; j++)
            if (t == ack_at[j]) sda = acks[j];
         send_tick(op, sda);
      end
   endtask

   initial begin
      do @(posedge clock); while (reset);

      // idle levels and an unused operation before any command
      send_tick(OP_TICK, 1'b0);
      send_tick(OP_UNUSED, 1'b1);

      // zero ticks per unit: one byte read for a zero count, write with oversized count
      configure(8'hFF, 10'd0);
      run_transfer(1'b1, 8'h00, 8'hFF, 8'h00, 5'd0, 3'b000);
      run_transfer(1'b0, 8'hFF, 8'h00, 8'hFF, 5'd31, 3'b000);

      // two ticks per unit, write with address nack
      configure(8'($urandom), 10'd2);
      run_transfer(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 5'd0, 3'b001);
      repeat (2) send_tick(OP_UNUSED, 1'($urandom));

      // back to back: read with address nack
      calm = 1'b1;
      configure(8'($urandom), 10'd1);
      run_transfer(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 5'd2, 3'b001);
      repeat (3) send_tick(OP_TICK, 1'($urandom));

      drain_responses();
      repeat (4) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> sccb_register_master_unit.f
design/sccbm_pkg.sv
design/sccbm_fsm.sv
design/sccbm_rsp_reg.sv
design/sccb_register_master_unit.sv
verif/sccbm_tick_checker.sv
verif/sccb_register_master_unit_test.sv
